@@ design/fpd_pkg.sv @@
// Shared constants and codes for the firmware packet deframer.
package fpd_pkg;

    localparam int PAGE_BYTES = 2048;
    localparam int PFILL_W    = $clog2(PAGE_BYTES + 1);
    localparam int OFF_W      = 11;
    localparam int EV_W       = 3;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HUNT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TOPIC   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INDEX   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PAYLOAD = 3'd4;

    localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
    localparam logic [EV_W-1:0] EV_READY  = 3'd1;
    localparam logic [EV_W-1:0] EV_PROMPT = 3'd2;
    localparam logic [EV_W-1:0] EV_DONE   = 3'd3;
    localparam logic [EV_W-1:0] EV_PAGE   = 3'd4;
    localparam logic [EV_W-1:0] EV_RESEND = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPIC_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORED_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPIC_TAG   = 2'd3;

    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_PROMPT = 8'h3E;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [15:0] ASCII_ZERO = 16'h0030;

endpackage

@@ design/firmware_packet_deframer.sv @@
// Firmware packet deframer: publish header, topic, packet number and payload parser.
//
// Takes one item per cycle: a received byte (s_func low) or a start command (s_func high),
// and returns exactly one result item for each. An item is held in the input register and
// is then resolved into the result register, and throughput is one item per cycle; the only
// stall is m_ready held low. The parse state (mode, five-byte window, packet and page
// counters) updates as each item moves into the result register. Configuration writes
// take effect at once and no clearing pass follows reset.
module firmware_packet_deframer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [fpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [7:0]                     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fpd_pkg::EV_W-1:0]       m_event_res,
    output logic                           m_data_valid,
    output logic [7:0]                     m_data_byte,
    output logic [fpd_pkg::OFF_W-1:0]      m_page_offset,
    output logic [15:0]                    m_packet_number
);
    import fpd_pkg::*;

    logic [7:0]         hdr_type_reg;
    logic [7:0]         topic_len_reg;
    logic [7:0]         ign_len_reg;
    logic [31:0]        topic_tag_reg;

    logic               in_vld_reg;
    logic               func_reg;
    logic [7:0]         byte_reg;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [7:0]         win_reg [5];
    logic [7:0]         win_next [5];
    logic [15:0]        last_pkt_reg, last_pkt_next;
    logic [PFILL_W-1:0] pfill_reg, pfill_next;
    logic [7:0]         pcount_reg, pcount_next;
    logic [7:0]         msg_len_reg, msg_len_next;

    logic               m_valid_reg;
    logic [EV_W-1:0]    ev_reg, ev_next;
    logic               dv_reg, dv_next;
    logic [7:0]         db_reg, db_next;
    logic [OFF_W-1:0]   off_reg, off_next;

    logic               advance;
    logic               fire;
    logic               crlf;
    logic [15:0]        pkt_num;
    logic [PFILL_W-1:0] pfill_inc;
    logic [7:0]         pcount_inc;
    logic signed [9:0]  need;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_vld_reg || advance;
    assign fire    = in_vld_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_type_reg  <= 8'd48;
            topic_len_reg <= 8'd16;
            ign_len_reg   <= 8'd17;
            topic_tag_reg <= 32'h5545_626F;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_HEADER_TYPE: hdr_type_reg  <= cfg_wdata[7:0];
                CFG_TOPIC_LEN:   topic_len_reg <= cfg_wdata[7:0];
                CFG_IGNORED_LEN: ign_len_reg   <= cfg_wdata[7:0];
                CFG_TOPIC_TAG:   topic_tag_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            func_reg <= s_func;
            byte_reg <= s_rx_byte;
        end
    end

    assign pkt_num = ((({8'h00, win_reg[1]}) - ASCII_ZERO) * 16'd1000)
                   + ((({8'h00, win_reg[2]}) - ASCII_ZERO) * 16'd100)
                   + ((({8'h00, win_reg[3]}) - ASCII_ZERO) * 16'd10)
                   + (({8'h00, win_reg[4]}) - ASCII_ZERO);
    assign pfill_inc  = pfill_reg + PFILL_W'(1);
    assign pcount_inc = pcount_reg + 8'd1;
    assign need       = $signed({2'b00, msg_len_reg}) - $signed({2'b00, ign_len_reg});

    always_comb begin
        mode_next     = mode_reg;
        win_next      = win_reg;
        last_pkt_next = last_pkt_reg;
        pfill_next    = pfill_reg;
        pcount_next   = pcount_reg;
        msg_len_next  = msg_len_reg;
        ev_next       = EV_NONE;
        dv_next       = 1'b0;
        db_next       = 8'h00;
        off_next      = '0;
        crlf          = 1'b0;
        if (func_reg) begin
            ev_next       = EV_READY;
            last_pkt_next = 16'd0;
            mode_next     = MODE_HUNT;
            for (int i = 0; i < 5; i++) win_next[i] = 8'h00;
        end else begin
            unique case (mode_reg)
                MODE_HUNT: begin
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    win_next[3] = win_reg[4];
                    win_next[4] = byte_reg;
                    crlf = (win_reg[4] == CHAR_CR) && (byte_reg == CHAR_LF);
                    if (byte_reg == CHAR_PROMPT || crlf) begin
                        if (byte_reg == CHAR_PROMPT) ev_next = EV_PROMPT;
                        for (int i = 0; i < 5; i++) win_next[i] = 8'h00;
                    end else if (win_reg[2] == hdr_type_reg && byte_reg == topic_len_reg) begin
                        msg_len_next = win_reg[3];
                        pcount_next  = 8'd0;
                        mode_next    = MODE_TOPIC;
                    end
                end
                MODE_TOPIC: begin
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    win_next[3] = win_reg[4];
                    win_next[4] = byte_reg;
                    crlf = (win_reg[4] == CHAR_CR) && (byte_reg == CHAR_LF);
                    if (crlf) begin
                        mode_next = MODE_HUNT;
                        for (int i = 0; i < 5; i++) win_next[i] = 8'h00;
                    end else if ({win_reg[2], win_reg[3], win_reg[4], byte_reg}
                                 == topic_tag_reg) begin
                        mode_next = MODE_INDEX;
                    end
                end
                MODE_INDEX: begin
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = win_reg[3];
                    win_next[3] = win_reg[4];
                    win_next[4] = byte_reg;
                    crlf = (win_reg[4] == CHAR_CR) && (byte_reg == CHAR_LF);
                    if (crlf) begin
                        mode_next = MODE_HUNT;
                        for (int i = 0; i < 5; i++) win_next[i] = 8'h00;
                    end else if (byte_reg == CHAR_COLON) begin
                        if ({1'b0, pkt_num} == {1'b0, last_pkt_reg} + 17'd1) begin
                            last_pkt_next = pkt_num;
                            mode_next     = MODE_PAYLOAD;
                        end else begin
                            ev_next   = EV_RESEND;
                            mode_next = MODE_HUNT;
                            for (int i = 0; i < 5; i++) win_next[i] = 8'h00;
                        end
                    end
                end
                MODE_PAYLOAD: begin
                    win_next[3] = win_reg[4];
                    win_next[4] = byte_reg;
                    crlf = (win_reg[4] == CHAR_CR) && (byte_reg == CHAR_LF);
                    if (crlf) begin
                        mode_next = MODE_HUNT;
                        for (int i = 0; i < 5; i++) win_next[i] = 8'h00;
                    end else begin
                        dv_next     = 1'b1;
                        db_next     = byte_reg;
                        off_next    = OFF_W'(pfill_reg);
                        pfill_next  = pfill_inc;
                        pcount_next = pcount_inc;
                        if (pfill_inc == PFILL_W'(PAGE_BYTES)) begin
                            ev_next    = EV_PAGE;
                            pfill_next = '0;
                            mode_next  = MODE_HUNT;
                            for (int i = 0; i < 5; i++) win_next[i] = 8'h00;
                        end else if ($signed({2'b00, pcount_inc}) >= need) begin
                            ev_next   = EV_DONE;
                            mode_next = MODE_HUNT;
                            for (int i = 0; i < 5; i++) win_next[i] = 8'h00;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            last_pkt_reg <= 16'd0;
            pfill_reg    <= '0;
            pcount_reg   <= 8'd0;
            msg_len_reg  <= 8'd0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < 5; i++) win_reg[i] <= 8'h00;
        end else begin
            if (advance) begin
                m_valid_reg <= in_vld_reg;
            end
            if (fire) begin
                mode_reg     <= mode_next;
                win_reg      <= win_next;
                last_pkt_reg <= last_pkt_next;
                pfill_reg    <= pfill_next;
                pcount_reg   <= pcount_next;
                msg_len_reg  <= msg_len_next;
            end
        end
        if (fire) begin
            ev_reg  <= ev_next;
            dv_reg  <= dv_next;
            db_reg  <= db_next;
            off_reg <= off_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_res     = ev_reg;
    assign m_data_valid    = dv_reg;
    assign m_data_byte     = db_reg;
    assign m_page_offset   = off_reg;
    assign m_packet_number = last_pkt_reg;

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pfill_reg < PFILL_W'(PAGE_BYTES))
        else $error("page fill reached page size");

    a_data_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_valid) |->
            (m_event_res == EV_NONE || m_event_res == EV_DONE || m_event_res == EV_PAGE))
        else $error("payload byte with unexpected event");

    a_resend_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ev_next == EV_RESEND) |=> (last_pkt_reg == $past(last_pkt_reg)))
        else $error("resend changed packet number");

    a_payload_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && mode_reg == MODE_INDEX && mode_next == MODE_PAYLOAD) |=>
            (last_pkt_reg == $past(last_pkt_reg) + 16'd1))
        else $error("packet number did not advance by one");

endmodule
